// ===== sv/tsw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tsw_pkg;

  localparam int MAX_PAYLOAD = 1452;
  localparam int QUEUE_DEPTH = 64;
  localparam int MAX_SEGS    = 63;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int QS_W        = QA_W + 1;
  localparam int NSEG_W      = 6;

  localparam logic [2:0] OP_WRITE = 3'd0;
  localparam logic [2:0] OP_END   = 3'd1;
  localparam logic [2:0] OP_FILL  = 3'd2;
  localparam logic [2:0] OP_ACK   = 3'd3;
  localparam logic [2:0] OP_TICK  = 3'd4;
  localparam logic [2:0] OP_EMPTY = 3'd5;

  localparam logic [1:0] REG_ISN     = 2'd0;
  localparam logic [1:0] REG_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_CAP     = 2'd2;

  typedef enum logic [2:0] {
    CMD_WRITE, CMD_END, CMD_FILL, CMD_ACK, CMD_TICK, CMD_EMPTY, CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] byte_count;
    logic [31:0] ack_off;
    logic [15:0] window;
    logic [15:0] elapsed_ms;
  } cmd_t;

  typedef struct packed {
    logic [31:0] initial_seqno;
    logic [15:0] initial_timeout_ms;
    logic [15:0] stream_capacity;
  } cfg_t;

  typedef struct packed {
    logic [31:0] seq;
    logic [15:0] len;
    logic        syn;
    logic        fin;
  } qent_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] seg_seqno;
    logic [15:0] payload_len;
    logic        syn_flag;
    logic        fin_flag;
    logic        is_retransmit;
    logic        ack_valid;
    logic [15:0] accepted_bytes;
    logic [15:0] in_flight;
    logic [7:0]  retx_count;
    logic        last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISPATCH, ST_FILL, ST_SEG_OUT, ST_ACK_A, ST_ACK_B, ST_RET_RD,
    ST_RET_CHK, ST_ACK_POST, ST_TICK_A, ST_TICK_B, ST_STATUS
  } bk_state_t;

endpackage
`default_nettype wire

// ===== sv/tsw_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface tsw_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [15:0] byte_count;
  logic [31:0] ack_seqno;
  logic [15:0] window;
  logic [15:0] elapsed_ms;
  modport source (output valid, op, byte_count, ack_seqno, window, elapsed_ms,
                  input ready);
  modport sink (input valid, op, byte_count, ack_seqno, window, elapsed_ms,
                output ready);
endinterface

interface tsw_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] seg_seqno;
  logic [15:0] payload_len;
  logic        syn_flag;
  logic        fin_flag;
  logic        is_retransmit;
  logic        ack_valid;
  logic [15:0] accepted_bytes;
  logic [15:0] in_flight;
  logic [7:0]  retx_count;
  logic        last;
  modport source (output valid, kind, seg_seqno, payload_len, syn_flag, fin_flag,
                  is_retransmit, ack_valid, accepted_bytes, in_flight, retx_count,
                  last, input ready);
  modport sink (input valid, kind, seg_seqno, payload_len, syn_flag, fin_flag,
                is_retransmit, ack_valid, accepted_bytes, in_flight, retx_count,
                last, output ready);
endinterface
`default_nettype wire

// ===== sv/tcp_sender_window_retransmit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  handshake       payload
// in_ch     in   valid/ready     op, byte_count, ack_seqno, window, elapsed_ms
// out_ch    out  valid/ready     segment descriptors, then one status beat (last)
// cfg_*     in   APB, pready=1   initial_seqno, initial_timeout_ms, stream_capacity
//
// Commands go through a 2-deep queue to a sequencer that runs one at a time.
// Write/end/nop: take, dispatch, status. A fill adds a fill step, then fill and output
// per segment; a retired entry: read, check (registered read of the outstanding queue
// RAM head). An ack adds unwrap and compare, then retire, fill, post if it advances; a
// tick: an update, or a resend too. Every result beat can be held by out stalls.
// Synchronous active-low reset; no clearing pass on the queue RAM.
// Output stalls hold the sequencer; the input queue keeps taking beats until full.
module tcp_sender_window_retransmit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  tsw_in_if.sink           in_ch,
  tsw_out_if.source        out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  import tsw_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  logic wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_paddr[3:2])
        REG_ISN:     cfg_nxt.initial_seqno      = cfg_pwdata;
        REG_TIMEOUT: cfg_nxt.initial_timeout_ms = cfg_pwdata[15:0];
        REG_CAP:     cfg_nxt.stream_capacity    = cfg_pwdata[15:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
    unique case (cfg_paddr[3:2])
      REG_ISN:     cfg_prdata = cfg_r.initial_seqno;
      REG_TIMEOUT: cfg_prdata = {16'd0, cfg_r.initial_timeout_ms};
      REG_CAP:     cfg_prdata = {16'd0, cfg_r.stream_capacity};
      default:     cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{initial_seqno: 32'd0, initial_timeout_ms: 16'd1000,
                 stream_capacity: 16'hFFFF};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tsw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready)
  );

  tsw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .out_ch    (out_ch)
  );
endmodule
`default_nettype wire

// ===== sv/tsw_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tsw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/tsw_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tsw_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire tsw_pkg::cfg_t cfg,
  tsw_in_if.sink             in_ch,
  output logic               cmd_valid,
  output tsw_pkg::cmd_t      cmd,
  input  wire logic          cmd_ready
);
  import tsw_pkg::*;

  cmd_t       fifo_r [2];
  logic       wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       dec;
  logic       push, pop;

  always_comb begin
    dec.byte_count = in_ch.byte_count;
    dec.ack_off    = in_ch.ack_seqno - cfg.initial_seqno;
    dec.window     = in_ch.window;
    dec.elapsed_ms = in_ch.elapsed_ms;
    unique case (in_ch.op)
      OP_WRITE: dec.kind = CMD_WRITE;
      OP_END:   dec.kind = CMD_END;
      OP_FILL:  dec.kind = CMD_FILL;
      OP_ACK:   dec.kind = CMD_ACK;
      OP_TICK:  dec.kind = CMD_TICK;
      OP_EMPTY: dec.kind = CMD_EMPTY;
      default:  dec.kind = CMD_NOP;
    endcase
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (cnt_r != 2'd0);
  assign cmd         = fifo_r[rptr_r];
  assign pop         = cmd_valid && cmd_ready;

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wptr_r] <= dec;
    end
  end
endmodule
`default_nettype wire

// ===== sv/tsw_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tsw_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire tsw_pkg::cfg_t cfg,
  input  wire logic          cmd_valid,
  input  wire tsw_pkg::cmd_t cmd,
  output logic               cmd_ready,
  tsw_out_if.source          out_ch
);
  import tsw_pkg::*;

  bk_state_t         state_r, state_nxt, ret_r, ret_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [63:0]       next_r, next_nxt, acked_r, acked_nxt, abs_r, abs_nxt;
  logic [15:0]       pw_r, pw_nxt, buf_r, buf_nxt, acc_r, acc_nxt;
  logic [16:0]       flight_r, flight_nxt, dist_r, dist_nxt;
  logic [16:0]       fwin_r, fwin_nxt;
  logic              syn_sent_r, syn_sent_nxt, fin_sent_r, fin_sent_nxt;
  logic              ended_r, ended_nxt, tact_r, tact_nxt;
  logic              ack_ok_r, ack_ok_nxt, from_ack_r, from_ack_nxt;
  logic [31:0]       elapsed_r, elapsed_nxt, tmo_r, tmo_nxt;
  logic [7:0]        retx_r, retx_nxt;
  logic [QA_W-1:0]   head_r, head_nxt;
  logic [QC_W-1:0]   count_r, count_nxt;
  logic [NSEG_W-1:0] nsegs_r, nsegs_nxt;
  qent_t             pseg_r, pseg_nxt;
  logic              prt_r, prt_nxt;
  out_item_t         out_r, out_nxt;
  logic              ovalid_r, ovalid_nxt;

  logic              ram_we;
  logic [QA_W-1:0]   ram_waddr;
  qent_t             ram_wdata, ram_rdata;
  logic              out_free;

  // fill datapath
  logic [16:0] win17, diff17, room17, size17, len17, lenf17;
  logic [15:0] rd16, bufn16;
  logic        f_syn, f_fin, f_go;
  logic [QS_W-1:0] slot_sum;
  // ack / retire / tick datapath
  logic [31:0] ack_lo, ack_hi;
  logic [63:0] unwrapped;
  logic [16:0] ent_len;
  logic [17:0] ret_sum;
  logic [32:0] el_sum;
  logic [31:0] el_sat;
  logic [15:0] free16;
  logic [QA_W-1:0] head_inc;

  tsw_ram #(.WIDTH($bits(qent_t)), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  assign out_free = !ovalid_r || out_ch.ready;

  always_comb begin
    win17  = (pw_r == 16'd0) ? 17'd1 : {1'b0, pw_r};
    diff17 = next_r[16:0] - acked_r[16:0];
    // window is held from the start of the fill; SYN resetting pw_r doesn't shrink it
    f_go   = !fin_sent_r && (fwin_r > diff17) && (count_r < QC_W'(QUEUE_DEPTH)) &&
             (nsegs_r < NSEG_W'(MAX_SEGS));
    room17 = fwin_r - diff17;
    f_syn  = !syn_sent_r;
    size17 = room17 - {16'd0, f_syn};
    if (size17 > 17'(MAX_PAYLOAD)) begin
      size17 = 17'(MAX_PAYLOAD);
    end
    rd16   = (size17 < {1'b0, buf_r}) ? size17[15:0] : buf_r;
    bufn16 = buf_r - rd16;
    len17  = {1'b0, rd16} + {16'd0, f_syn};
    f_fin  = (len17 < room17) && ended_r && (bufn16 == 16'd0);
    lenf17 = len17 + {16'd0, f_fin};
    slot_sum = QS_W'(head_r) + QS_W'(count_r);
    if (slot_sum >= QS_W'(QUEUE_DEPTH)) begin
      slot_sum = slot_sum - QS_W'(QUEUE_DEPTH);
    end
    head_inc = (head_r == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;

    // unwrap around the acked point: its upper word, or one less or one more on wrap
    ack_lo    = acked_r[31:0];
    ack_hi    = acked_r[63:32];
    unwrapped = {ack_hi, cmd_r.ack_off};
    if (cmd_r.ack_off > ack_lo && (cmd_r.ack_off - ack_lo) > 32'h8000_0000 &&
        ack_hi != 32'd0) begin
      unwrapped = {ack_hi - 32'd1, cmd_r.ack_off};
    end else if (cmd_r.ack_off < ack_lo && (ack_lo - cmd_r.ack_off) > 32'h8000_0000 &&
                 ack_hi != 32'hFFFF_FFFF) begin
      unwrapped = {ack_hi + 32'd1, cmd_r.ack_off};
    end

    ent_len = {1'b0, ram_rdata.len} + {16'd0, ram_rdata.syn} + {16'd0, ram_rdata.fin};
    ret_sum = {1'b0, ent_len} + {1'b0, dist_r};
    el_sum  = {1'b0, elapsed_r} + {17'd0, cmd_r.elapsed_ms};
    el_sat  = el_sum[32] ? 32'hFFFF_FFFF : el_sum[31:0];
    free16  = cfg.stream_capacity - buf_r;
  end

  always_comb begin
    state_nxt = state_r;   ret_nxt = ret_r;       cmd_nxt = cmd_r;
    next_nxt = next_r;     acked_nxt = acked_r;   abs_nxt = abs_r;
    pw_nxt = pw_r;         buf_nxt = buf_r;       acc_nxt = acc_r;
    flight_nxt = flight_r; dist_nxt = dist_r;     fwin_nxt = fwin_r;
    syn_sent_nxt = syn_sent_r; fin_sent_nxt = fin_sent_r;
    ended_nxt = ended_r;   tact_nxt = tact_r;
    ack_ok_nxt = ack_ok_r; from_ack_nxt = from_ack_r;
    elapsed_nxt = elapsed_r; tmo_nxt = tmo_r;     retx_nxt = retx_r;
    head_nxt = head_r;     count_nxt = count_r;   nsegs_nxt = nsegs_r;
    pseg_nxt = pseg_r;     prt_nxt = prt_r;
    out_nxt = out_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    cmd_ready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = slot_sum[QA_W-1:0];
    ram_wdata = '{seq: cfg.initial_seqno + next_r[31:0], len: rd16, syn: f_syn,
                  fin: f_fin};

    unique case (state_r)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cmd_nxt      = cmd;
          nsegs_nxt    = '0;
          ack_ok_nxt   = 1'b1;
          acc_nxt      = 16'd0;
          from_ack_nxt = 1'b0;
          state_nxt    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (cmd_r.kind)
          CMD_WRITE: begin
            if (!ended_r && cfg.stream_capacity > buf_r) begin
              acc_nxt = (cmd_r.byte_count < free16) ? cmd_r.byte_count : free16;
              buf_nxt = buf_r + acc_nxt;
            end
            state_nxt = ST_STATUS;
          end
          CMD_END: begin
            ended_nxt = 1'b1;
            state_nxt = ST_STATUS;
          end
          CMD_FILL: begin
            fwin_nxt  = win17;
            state_nxt = ST_FILL;
          end
          CMD_ACK:   state_nxt = ST_ACK_A;
          CMD_TICK:  state_nxt = ST_TICK_A;
          CMD_EMPTY: begin
            pseg_nxt  = '{seq: cfg.initial_seqno + next_r[31:0], len: 16'd0,
                          syn: 1'b0, fin: 1'b0};
            prt_nxt   = 1'b0;
            ret_nxt   = ST_STATUS;
            state_nxt = ST_SEG_OUT;
          end
          default: state_nxt = ST_STATUS;
        endcase
      end
      ST_FILL: begin
        if (f_go && lenf17 != 17'd0) begin
          if (f_syn) begin
            syn_sent_nxt = 1'b1;
            pw_nxt       = 16'd1;
          end
          if (f_fin) begin
            fin_sent_nxt = 1'b1;
          end
          buf_nxt = bufn16;
          if (count_r == '0) begin
            tmo_nxt     = {16'd0, cfg.initial_timeout_ms};
            elapsed_nxt = 32'd0;
          end
          if (!tact_r) begin
            tact_nxt    = 1'b1;
            elapsed_nxt = 32'd0;
          end
          ram_we     = 1'b1;
          count_nxt  = count_r + 1'b1;
          next_nxt   = next_r + {47'd0, lenf17};
          flight_nxt = flight_r + lenf17;
          nsegs_nxt  = nsegs_r + 1'b1;
          pseg_nxt   = ram_wdata;
          prt_nxt    = 1'b0;
          ret_nxt    = ST_FILL;
          state_nxt  = ST_SEG_OUT;
        end else begin
          state_nxt = from_ack_r ? ST_ACK_POST : ST_STATUS;
        end
      end
      ST_SEG_OUT: begin
        if (out_free) begin
          out_nxt = '{kind: 1'b0, seg_seqno: pseg_r.seq, payload_len: pseg_r.len,
                      syn_flag: pseg_r.syn, fin_flag: pseg_r.fin,
                      is_retransmit: prt_r, ack_valid: 1'b0, accepted_bytes: 16'd0,
                      in_flight: 16'd0, retx_count: 8'd0, last: 1'b0};
          ovalid_nxt = 1'b1;
          state_nxt  = ret_r;
        end
      end
      ST_ACK_A: begin
        abs_nxt   = unwrapped;
        state_nxt = ST_ACK_B;
      end
      ST_ACK_B: begin
        if (abs_r > next_r) begin
          ack_ok_nxt = 1'b0;
          state_nxt  = ST_STATUS;
        end else begin
          pw_nxt = cmd_r.window;
          if (abs_r > acked_r) begin
            acked_nxt    = abs_r;
            dist_nxt     = next_r[16:0] - abs_r[16:0];
            from_ack_nxt = 1'b1;
            state_nxt    = ST_RET_RD;
          end else begin
            state_nxt = ST_STATUS;
          end
        end
      end
      ST_RET_RD: begin
        // head entry is read every cycle; data is ready in the next state
        if (count_r != '0) begin
          state_nxt = ST_RET_CHK;
        end else begin
          fwin_nxt  = win17;
          state_nxt = ST_FILL;
        end
      end
      ST_RET_CHK: begin
        if (ret_sum > {1'b0, flight_r}) begin
          fwin_nxt  = win17;
          state_nxt = ST_FILL;
        end else begin
          flight_nxt = flight_r - ent_len;
          head_nxt   = head_inc;
          count_nxt  = count_r - 1'b1;
          state_nxt  = ST_RET_RD;
        end
      end
      ST_ACK_POST: begin
        tmo_nxt  = {16'd0, cfg.initial_timeout_ms};
        retx_nxt = 8'd0;
        if (count_r != '0) begin
          tact_nxt    = 1'b1;
          elapsed_nxt = 32'd0;
        end
        state_nxt = ST_STATUS;
      end
      ST_TICK_A: begin
        elapsed_nxt = el_sat;
        if (el_sat >= tmo_r && count_r != '0) begin
          state_nxt = ST_TICK_B;
        end else begin
          if (count_r == '0) begin
            tact_nxt = 1'b0;
          end
          state_nxt = ST_STATUS;
        end
      end
      ST_TICK_B: begin
        pseg_nxt = ram_rdata;
        prt_nxt  = 1'b1;
        if (retx_r != 8'hFF) begin
          retx_nxt = retx_r + 8'd1;
        end
        if (pw_r != 16'd0) begin
          tmo_nxt = (tmo_r > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF : {tmo_r[30:0], 1'b0};
        end
        tact_nxt    = 1'b1;
        elapsed_nxt = 32'd0;
        ret_nxt     = ST_STATUS;
        state_nxt   = ST_SEG_OUT;
      end
      ST_STATUS: begin
        if (out_free) begin
          out_nxt = '{kind: 1'b1, seg_seqno: 32'd0, payload_len: 16'd0,
                      syn_flag: 1'b0, fin_flag: 1'b0, is_retransmit: 1'b0,
                      ack_valid: ack_ok_r, accepted_bytes: acc_r,
                      in_flight: flight_r[16] ? 16'hFFFF : flight_r[15:0],
                      retx_count: retx_r, last: 1'b1};
          ovalid_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      ret_r      <= ST_IDLE;
      next_r     <= 64'd0;
      acked_r    <= 64'd0;
      pw_r       <= 16'd1;
      flight_r   <= 17'd0;
      syn_sent_r <= 1'b0;
      fin_sent_r <= 1'b0;
      elapsed_r  <= 32'd0;
      tmo_r      <= 32'd0;
      tact_r     <= 1'b0;
      retx_r     <= 8'd0;
      buf_r      <= 16'd0;
      ended_r    <= 1'b0;
      head_r     <= '0;
      count_r    <= '0;
      ovalid_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ret_r      <= ret_nxt;
      next_r     <= next_nxt;
      acked_r    <= acked_nxt;
      pw_r       <= pw_nxt;
      flight_r   <= flight_nxt;
      syn_sent_r <= syn_sent_nxt;
      fin_sent_r <= fin_sent_nxt;
      elapsed_r  <= elapsed_nxt;
      tmo_r      <= tmo_nxt;
      tact_r     <= tact_nxt;
      retx_r     <= retx_nxt;
      buf_r      <= buf_nxt;
      ended_r    <= ended_nxt;
      head_r     <= head_nxt;
      count_r    <= count_nxt;
      ovalid_r   <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    abs_r      <= abs_nxt;
    dist_r     <= dist_nxt;
    fwin_r     <= fwin_nxt;
    acc_r      <= acc_nxt;
    ack_ok_r   <= ack_ok_nxt;
    from_ack_r <= from_ack_nxt;
    nsegs_r    <= nsegs_nxt;
    pseg_r     <= pseg_nxt;
    prt_r      <= prt_nxt;
    out_r      <= out_nxt;
  end

  assign out_ch.valid          = ovalid_r;
  assign out_ch.kind           = out_r.kind;
  assign out_ch.seg_seqno      = out_r.seg_seqno;
  assign out_ch.payload_len    = out_r.payload_len;
  assign out_ch.syn_flag       = out_r.syn_flag;
  assign out_ch.fin_flag       = out_r.fin_flag;
  assign out_ch.is_retransmit  = out_r.is_retransmit;
  assign out_ch.ack_valid      = out_r.ack_valid;
  assign out_ch.accepted_bytes = out_r.accepted_bytes;
  assign out_ch.in_flight      = out_r.in_flight;
  assign out_ch.retx_count     = out_r.retx_count;
  assign out_ch.last           = out_r.last;
endmodule
`default_nettype wire

// ===== sv/tsw_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tsw_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_kind,
  input wire logic        out_last,
  input wire logic [31:0] out_seg_seqno,
  input wire logic [15:0] out_payload_len,
  input wire logic        out_ack_valid,
  input wire logic [15:0] out_in_flight
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_seg_seqno))
    else $error("out beat dropped while stalled");

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == out_kind))
    else $error("last not on status beat");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind |-> (out_seg_seqno == 32'd0) && (out_payload_len == 16'd0))
    else $error("status beat carries segment fields");

  a_seg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kind |-> !out_ack_valid && (out_in_flight == 16'd0))
    else $error("segment beat carries status fields");
endmodule

bind tcp_sender_window_retransmit tsw_chk u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_kind        (out_ch.kind),
  .out_last        (out_ch.last),
  .out_seg_seqno   (out_ch.seg_seqno),
  .out_payload_len (out_ch.payload_len),
  .out_ack_valid   (out_ch.ack_valid),
  .out_in_flight   (out_ch.in_flight)
);
`default_nettype wire
